[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the UTF-8 string validator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/usv_pkg.sv]
// Shared types, constants and helpers of the UTF-8 string validator.
package usv_pkg;

  localparam int CP_W      = 21;
  localparam int CNT_OUT_W = 17;
  localparam int LEN_W     = 3;

  localparam longint unsigned MAX_BYTES_DEF = 64'd65536;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_ILL   = 2'd2;

  localparam logic [CP_W-1:0] CP_ALL_ONES   = '1;
  localparam logic [CP_W-1:0] CP_MAX_LEGAL  = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_TWO_MIN    = 21'h000080;
  localparam logic [CP_W-1:0] CP_THREE_MIN  = 21'h000800;
  localparam logic [CP_W-1:0] CP_FOUR_MIN   = 21'h010000;
  localparam logic [CP_W-1:0] CP_SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_LIMIT      = 21'h110000;

  // Per-string decoder state (counters live in the top level)
  typedef struct packed {
    logic [LEN_W-1:0] exp_len;
    logic [LEN_W-1:0] rcv;
    logic [CP_W-1:0]  partial;
    logic [CP_W-1:0]  min_seen;
    logic [CP_W-1:0]  max_seen;
    logic             malformed;
  } dec_state_t;

  localparam dec_state_t DEC_CLEAR = '{
    exp_len:   '0,
    rcv:       '0,
    partial:   '0,
    min_seen:  CP_ALL_ONES,
    max_seen:  '0,
    malformed: 1'b0
  };

  // Number of bytes of the shortest legal encoding; zero for no legal form
  function automatic logic [LEN_W-1:0] encoded_size(input logic [CP_W-1:0] cp);
    logic [LEN_W-1:0] sz;
    if (cp < CP_TWO_MIN) begin
      sz = 3'd1;
    end else if (cp < CP_THREE_MIN) begin
      sz = 3'd2;
    end else if (cp < CP_FOUR_MIN) begin
      sz = (cp >= CP_SURR_LO && cp <= CP_SURR_HI) ? 3'd0 : 3'd3;
    end else if (cp < CP_LIMIT) begin
      sz = 3'd4;
    end else begin
      sz = 3'd0;
    end
    return sz;
  endfunction

endpackage

[hw/rtl/utf8_string_validator.sv]
// Top level of the UTF-8 string validator: input register, decode, result register.
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_tvalid/s_tready  one string byte per item, tlast ends string
//  m_*       out        m_tvalid/m_tready  one result item per string
//  cfg_*     in         cfg_we             code-point bounds, index 0 min, 1 max
//
// One item per cycle is taken while no last item stalls; a byte reaches the decoder in the
// cycle after it is accepted, and a string's result reaches m_* through the input register
// and then the result register. The input register and the result register each hold one
// item, so the next string's bytes keep flowing while a result waits; only a last item
// stalls when the result register is still full. Reset (rst, synchronous) empties
// both registers, clears the string state and restores the bounds.
`include "assert_macros.svh"

module utf8_string_validator #(
  parameter longint unsigned MAX_BYTES = usv_pkg::MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] has_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [18:2] code_point_count, [35:19] byte_length,
  // [56:36] min_code_point, [77:57] max_code_point, [79:78] zero
  output logic [79:0] m_tdata,
  output logic [0:0]  m_tuser,   // [0] stats_valid
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [20:0] cfg_data
);
  import usv_pkg::*;

  localparam int CNT_W = $clog2(MAX_BYTES + 64'd1);
  localparam int EXT_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_BYTES);

  localparam logic [0:0] REG_MIN = 1'b0;
  localparam logic [0:0] REG_MAX = 1'b1;

  // Bounds
  logic [CP_W-1:0] min_accepted;
  logic [CP_W-1:0] max_accepted;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_has;
  logic       in_last;

  // String state
  dec_state_t      dec;
  dec_state_t      dec_next;
  logic            accept;
  logic [CNT_W-1:0] point_count;
  logic [CNT_W-1:0] total_bytes;
  logic [CNT_W-1:0] point_count_next;
  logic [CNT_W-1:0] total_bytes_next;

  // Result register
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [CNT_OUT_W-1:0] out_count;
  logic [CNT_OUT_W-1:0] out_length;
  logic [CP_W-1:0]      out_min;
  logic [CP_W-1:0]      out_max;
  logic                 out_stats;

  logic                 advance;
  logic                 ends_ill;
  logic                 in_bounds;
  logic [EXT_W-1:0]     count_ext;
  logic [EXT_W-1:0]     length_ext;

  // Move the held item on unless its result has nowhere to go
  assign advance  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Hold configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_accepted <= '0;
      max_accepted <= CP_MAX_LEGAL;
    end else if (cfg_we) begin
      if (cfg_addr == REG_MIN) begin
        min_accepted <= cfg_data;
      end
      if (cfg_addr == REG_MAX) begin
        max_accepted <= cfg_data;
      end
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_has  <= s_tuser[0];
      in_last <= s_tlast;
    end
  end

  usv_step u_step (
    .cur       (dec),
    .data_byte (in_byte),
    .has_byte  (in_has),
    .nxt       (dec_next),
    .accept    (accept)
  );

  // Saturating counters
  always_comb begin
    point_count_next = point_count;
    total_bytes_next = total_bytes;
    if (accept && point_count != CNT_SAT) begin
      point_count_next = point_count + 1'b1;
    end
    if (in_has && total_bytes != CNT_SAT) begin
      total_bytes_next = total_bytes + 1'b1;
    end
  end

  assign ends_ill   = dec_next.malformed || (dec_next.exp_len != '0);
  assign in_bounds  = (dec_next.min_seen >= min_accepted) &&
                      (dec_next.max_seen <= max_accepted);
  assign count_ext  = EXT_W'(point_count_next);
  assign length_ext = EXT_W'(total_bytes_next);

  // Advance the string state; clear it when the string ends
  always_ff @(posedge clk) begin
    if (rst) begin
      dec         <= DEC_CLEAR;
      point_count <= '0;
      total_bytes <= '0;
    end else if (advance) begin
      if (in_last) begin
        dec         <= DEC_CLEAR;
        point_count <= '0;
        total_bytes <= '0;
      end else begin
        dec         <= dec_next;
        point_count <= point_count_next;
        total_bytes <= total_bytes_next;
      end
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Build the result item at the end of a string
  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_status <= STATUS_OK;
      out_count  <= '0;
      out_length <= '0;
      out_min    <= '0;
      out_max    <= '0;
      out_stats  <= 1'b0;
      if (ends_ill) begin
        out_status <= STATUS_ILL;
      end else if (total_bytes_next != '0) begin
        out_stats <= 1'b1;
        out_min   <= dec_next.min_seen;
        out_max   <= dec_next.max_seen;
        if (in_bounds) begin
          out_count  <= count_ext[CNT_OUT_W-1:0];
          out_length <= length_ext[CNT_OUT_W-1:0];
        end else begin
          out_status <= STATUS_RANGE;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_max, out_min, out_length, out_count, out_status};
  assign m_tuser  = out_stats;

  // A last item never overwrites a result that is still waiting
  `ASSERT_NOW(a_no_overwrite, out_valid && !m_tready, !(advance && in_last),
              "last item advanced over a waiting result")
  // A result that leaves the input side fills the result register
  `ASSERT_NEXT(a_result_loaded, advance && in_last, out_valid,
               "string end did not produce a result")
  // Ill-formed results carry no statistics
  `ASSERT_NOW(a_ill_empty, out_valid && out_status == STATUS_ILL,
              !out_stats && out_count == '0 && out_length == '0,
              "ill-formed result carries statistics")
  // A sequence in progress has seen its lead byte and is not yet complete
  `ASSERT_NOW(a_seq_count, dec.exp_len != '0,
              dec.rcv != '0 && dec.rcv < dec.exp_len,
              "continuation count out of step with sequence length")

endmodule

[hw/rtl/usv_step.sv]
// One-byte decode step: next decoder state and any completed code point.
module usv_step (
  input  usv_pkg::dec_state_t          cur,
  input  logic [7:0]                   data_byte,
  input  logic                         has_byte,
  output usv_pkg::dec_state_t          nxt,
  output logic                         accept
);
  import usv_pkg::*;

  logic [CP_W-1:0]  cp;
  logic [CP_W-1:0]  joined;
  logic [LEN_W-1:0] rcv_inc;

  assign joined  = {cur.partial[CP_W-7:0], data_byte[5:0]};
  assign rcv_inc = cur.rcv + 3'd1;

  // Decode the byte against the sequence in progress
  always_comb begin
    nxt    = cur;
    accept = 1'b0;
    cp     = '0;
    if (has_byte && !cur.malformed) begin
      if (cur.exp_len == 3'd0) begin
        if (data_byte inside {[8'h00:8'h7F]}) begin
          accept = 1'b1;
          cp     = CP_W'(data_byte);
        end else if (data_byte inside {[8'hC0:8'hDF]}) begin
          nxt.exp_len = 3'd2;
          nxt.rcv     = 3'd1;
          nxt.partial = CP_W'(data_byte[4:0]);
        end else if (data_byte inside {[8'hE0:8'hEF]}) begin
          nxt.exp_len = 3'd3;
          nxt.rcv     = 3'd1;
          nxt.partial = CP_W'(data_byte[3:0]);
        end else if (data_byte inside {[8'hF0:8'hF7]}) begin
          nxt.exp_len = 3'd4;
          nxt.rcv     = 3'd1;
          nxt.partial = CP_W'(data_byte[2:0]);
        end else begin
          nxt.malformed = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        nxt.malformed = 1'b1;
      end else if (rcv_inc >= cur.exp_len) begin
        // Sequence complete: reject overlong, surrogate and out-of-range values
        if (encoded_size(joined) != cur.exp_len) begin
          nxt.malformed = 1'b1;
        end else begin
          accept = 1'b1;
          cp     = joined;
        end
        nxt.exp_len = '0;
        nxt.rcv     = '0;
        nxt.partial = '0;
      end else begin
        nxt.partial = joined;
        nxt.rcv     = rcv_inc;
      end
    end
    // Track extremes of accepted code points
    if (accept) begin
      if (cp < cur.min_seen) begin
        nxt.min_seen = cp;
      end
      if (cp > cur.max_seen) begin
        nxt.max_seen = cp;
      end
    end
  end

endmodule

[bench/usv_result_checker.sv]
// Register indexes and the result checker of the UTF-8 string validator bench.
package usv_bench_pkg;

  localparam logic [0:0] REG_MIN_ACCEPTED = 1'b0;
  localparam logic [0:0] REG_MAX_ACCEPTED = 1'b1;

endpackage

module usv_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [20:0] cfg_data,
  output int          errors,
  output int          pending
);

  import usv_pkg::*;
  import usv_bench_pkg::*;

  localparam longint unsigned COUNT_CAP = MAX_BYTES_DEF;

  // One predicted string verdict
  typedef struct packed {
    logic [1:0]  status;
    logic [16:0] cp_count;
    logic [16:0] byte_len;
    logic [20:0] lo_cp;
    logic [20:0] hi_cp;
    logic        stats;
  } verdict_t;

  verdict_t verdicts[$];

  // Code-point bounds as last written
  logic [20:0] bound_lo;
  logic [20:0] bound_hi;

  // Decoder state of the string in progress
  logic [2:0]      seq_len;
  logic [2:0]      seq_got;
  logic [20:0]     acc_cp;
  longint unsigned n_points;
  longint unsigned n_bytes;
  logic [20:0]     lo_seen;
  logic [20:0]     hi_seen;
  bit              bad;
  int              results_seen;

  initial begin
    errors = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("checker: result %0d: %s", results_seen, msg);
    errors++;
  endtask

  // Length of the shortest legal encoding, zero where none exists
  function automatic logic [2:0] legal_size(input logic [20:0] cp);
    if (cp < 21'h80) return 3'd1;
    if (cp < 21'h800) return 3'd2;
    if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) return 3'd0;
    if (cp < 21'h10000) return 3'd3;
    if (cp <= CP_MAX_LEGAL) return 3'd4;
    return 3'd0;
  endfunction

  task automatic clear_string();
    seq_len  = 3'd0;
    seq_got  = 3'd0;
    acc_cp   = '0;
    n_points = 0;
    n_bytes  = 0;
    lo_seen  = CP_ALL_ONES;
    hi_seen  = '0;
    bad      = 1'b0;
  endtask

  task automatic note_point(input logic [20:0] cp);
    if (cp < lo_seen) lo_seen = cp;
    if (cp > hi_seen) hi_seen = cp;
    if (n_points < COUNT_CAP) n_points++;
  endtask

  // Advance the decoder by one byte
  task automatic absorb_byte(input logic [7:0] b);
    if (n_bytes < COUNT_CAP) n_bytes++;
    if (!bad) begin
      if (seq_len == 3'd0) begin
        if (!b[7]) begin
          note_point({13'd0, b});
        end else if (b < 8'hC0 || b >= 8'hF8) begin
          bad = 1'b1;
        end else begin
          casez (b[5:3])
            3'b0??: begin
              seq_len = 3'd2;
              acc_cp  = {16'd0, b[4:0]};
            end
            3'b10?: begin
              seq_len = 3'd3;
              acc_cp  = {17'd0, b[3:0]};
            end
            default: begin
              seq_len = 3'd4;
              acc_cp  = {18'd0, b[2:0]};
            end
          endcase
          seq_got = 3'd1;
        end
      end else if (b[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        acc_cp  = {acc_cp[14:0], b[5:0]};
        seq_got = seq_got + 3'd1;
        if (seq_got >= seq_len) begin
          if (legal_size(acc_cp) != seq_len) bad = 1'b1;
          else note_point(acc_cp);
          seq_len = 3'd0;
          seq_got = 3'd0;
          acc_cp  = '0;
        end
      end
    end
  endtask

  // Close the string and queue its verdict
  task automatic close_string();
    verdict_t v;
    v = '0;
    v.status = STATUS_OK;
    if (seq_len != 3'd0) bad = 1'b1;
    if (bad) begin
      v.status = STATUS_ILL;
    end else if (n_bytes != 0) begin
      v.stats = 1'b1;
      v.lo_cp = lo_seen;
      v.hi_cp = hi_seen;
      if (lo_seen >= bound_lo && hi_seen <= bound_hi) begin
        v.cp_count = n_points[16:0];
        v.byte_len = n_bytes[16:0];
      end else begin
        v.status = STATUS_RANGE;
      end
    end
    verdicts.push_back(v);
    clear_string();
  endtask

  // Compare one result item with the oldest verdict
  task automatic compare_result();
    verdict_t want;
    verdict_t got;
    got.status   = m_tdata[1:0];
    got.cp_count = m_tdata[18:2];
    got.byte_len = m_tdata[35:19];
    got.lo_cp    = m_tdata[56:36];
    got.hi_cp    = m_tdata[77:57];
    got.stats    = m_tuser[0];
    if (verdicts.size() == 0) begin
      report_mismatch($sformatf("no string pending, data %h", m_tdata));
    end else begin
      want = verdicts.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %h, want %h", got.status, want.status));
      if (got.cp_count !== want.cp_count)
        report_mismatch($sformatf("code_point_count %h, want %h", got.cp_count, want.cp_count));
      if (got.byte_len !== want.byte_len)
        report_mismatch($sformatf("byte_length %h, want %h", got.byte_len, want.byte_len));
      if (got.lo_cp !== want.lo_cp)
        report_mismatch($sformatf("min_code_point %h, want %h", got.lo_cp, want.lo_cp));
      if (got.hi_cp !== want.hi_cp)
        report_mismatch($sformatf("max_code_point %h, want %h", got.hi_cp, want.hi_cp));
      if (got.stats !== want.stats)
        report_mismatch($sformatf("stats_valid %b, want %b", got.stats, want.stats));
      if (m_tdata[79:78] !== 2'b00)
        report_mismatch($sformatf("padding bits %b", m_tdata[79:78]));
    end
    results_seen++;
  endtask

  // Watch the channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      bound_lo = '0;
      bound_hi = CP_MAX_LEGAL;
      clear_string();
      verdicts.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_MIN_ACCEPTED) bound_lo = cfg_data;
        else if (cfg_addr == REG_MAX_ACCEPTED) bound_hi = cfg_data;
      end
      if (m_tvalid && m_tready) compare_result();
      if (s_tvalid && s_tready) begin
        if (s_tuser[0]) absorb_byte(s_tdata);
        if (s_tlast) close_string();
      end
    end
    pending <= verdicts.size();
  end

endmodule

[bench/testbench.sv]
// Stimulus and final verdict of the UTF-8 string validator bench.
module testbench;

  import usv_pkg::*;
  import usv_bench_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 50;
  localparam int PHASES        = 8;

  // One input item as it goes onto the slave channel
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } str_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [0:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [20:0] cfg_data;

  int        errors;
  int        pending;
  bit        quiet = 1'b0;
  int        items_sent = 0;
  int        cycles = 0;
  int        ready_hold = 0;
  str_item_t string_items[$];

  utf8_string_validator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  usv_result_checker chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the result channel at random
  always @(negedge clk) begin
    if (quiet) begin
      ready_hold = 0;
      m_tready = 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      m_tready = 1'b0;
    end else if ($urandom_range(0, 99) < 75) begin
      m_tready = 1'b1;
    end else begin
      ready_hold = idle_len();
      m_tready = 1'b0;
    end
  end

  function automatic int size_for(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Legal code point, boundary values now and then
  function automatic logic [20:0] pick_point();
    case ($urandom_range(0, 9))
      0, 1, 2: return 21'($urandom_range(0, 21'h7F));
      3, 4:    return 21'($urandom_range(CP_TWO_MIN, 21'h7FF));
      5:       return 21'($urandom_range(CP_THREE_MIN, 21'hD7FF));
      6:       return 21'($urandom_range(21'hE000, 21'hFFFF));
      7:       return 21'($urandom_range(CP_FOUR_MIN, CP_MAX_LEGAL));
      default: begin
        case ($urandom_range(0, 9))
          0:       return 21'h0;
          1:       return 21'h7F;
          2:       return CP_TWO_MIN;
          3:       return 21'h7FF;
          4:       return CP_THREE_MIN;
          5:       return 21'hD7FF;
          6:       return 21'hE000;
          7:       return 21'hFFFF;
          8:       return CP_FOUR_MIN;
          default: return CP_MAX_LEGAL;
        endcase
      end
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    str_item_t it;
    it.data = b;
    it.has  = 1'b1;
    it.last = 1'b0;
    string_items.push_back(it);
  endtask

  task automatic push_ignored();
    str_item_t it;
    it.data = 8'($urandom);
    it.has  = 1'b0;
    it.last = 1'b0;
    string_items.push_back(it);
  endtask

  // Encode cp in n bytes, overlong where n is larger than needed
  task automatic put_point(input logic [20:0] cp, input int n);
    case (n)
      1: push_byte({1'b0, cp[6:0]});
      2: begin
        push_byte({3'b110, cp[10:6]});
        push_byte({2'b10, cp[5:0]});
      end
      3: begin
        push_byte({4'b1110, cp[15:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end
      default: begin
        push_byte({5'b11110, cp[20:18]});
        push_byte({2'b10, cp[17:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic send_item(input str_item_t it);
    int gap;
    gap = quiet ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = it.data;
    s_tuser  = it.has;
    s_tlast  = it.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (it.has || it.last) items_sent++;
  endtask

  // Mark the end of the string, then drive every item of it
  task automatic finish_and_send(input bit via_empty_item);
    str_item_t it;
    if (via_empty_item || string_items.size() == 0) begin
      it.data = 8'($urandom);
      it.has  = 1'b0;
      it.last = 1'b1;
      string_items.push_back(it);
    end else begin
      it = string_items[string_items.size() - 1];
      it.last = 1'b1;
      string_items[string_items.size() - 1] = it;
    end
    foreach (string_items[i]) send_item(string_items[i]);
    string_items.delete();
  endtask

  // Drop valid and let every result drain
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_bounds(input logic [20:0] lo, input logic [20:0] hi);
    wait_idle();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = REG_MIN_ACCEPTED;
    cfg_data = lo;
    @(negedge clk);
    cfg_addr = REG_MAX_ACCEPTED;
    cfg_data = hi;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // Break a well-formed string in one of several ways
  task automatic damage_string();
    str_item_t it;
    int        n;
    case ($urandom_range(0, 7))
      0: begin
        if (string_items.size() > 0) begin
          n = $urandom_range(0, string_items.size() - 1);
          it = string_items[n];
          it.data = 8'($urandom);
          string_items[n] = it;
        end
      end
      1: if (string_items.size() > 0) void'(string_items.pop_back());
      2: begin
        it.data = 8'($urandom);
        it.has  = 1'b1;
        it.last = 1'b0;
        string_items.insert($urandom_range(0, string_items.size()), it);
      end
      3: put_point(21'($urandom_range(CP_SURR_LO, CP_SURR_HI)), 3);
      4: begin
        n = $urandom_range(2, 4);
        case (n)
          2:       put_point(21'($urandom_range(0, 21'h7F)), n);
          3:       put_point(21'($urandom_range(0, 21'h7FF)), n);
          default: put_point(21'($urandom_range(0, 21'hFFFF)), n);
        endcase
      end
      5: put_point(21'($urandom_range(CP_LIMIT, CP_ALL_ONES)), 4);
      6: begin
        it.data = {2'b10, 6'($urandom)};
        it.has  = 1'b1;
        it.last = 1'b0;
        string_items.insert($urandom_range(0, string_items.size()), it);
      end
      default: begin
        push_byte({4'b1110, 4'($urandom)});
        push_byte({2'b10, 6'($urandom)});
      end
    endcase
  endtask

  // Mostly well-formed strings, some damaged, some noise, a few empty
  task automatic random_string();
    int          kind;
    int          npts;
    logic [20:0] cp;
    str_item_t   it;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 8)) begin
        it.data = 8'($urandom);
        it.has  = 1'($urandom_range(0, 1));
        it.last = 1'b0;
        string_items.push_back(it);
      end
    end else if (kind >= 14) begin
      npts = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
      repeat (npts) begin
        cp = pick_point();
        put_point(cp, size_for(cp));
      end
      if (kind < 40) damage_string();
    end
    if (string_items.size() > 0 && $urandom_range(0, 4) == 0) begin
      it.data = 8'($urandom);
      it.has  = 1'b0;
      it.last = 1'b0;
      string_items.insert($urandom_range(0, string_items.size()), it);
    end
    finish_and_send($urandom_range(0, 4) == 0);
  endtask

  initial begin
    logic [20:0] lo;
    logic [20:0] hi;
    int          start;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    s_tlast  = 1'b0;
    cfg_we   = 1'b0;
    cfg_addr = REG_MIN_ACCEPTED;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty string
    finish_and_send(1'b1);
    // Code point zero and the top of each longer encoding length, with an ignored item inside
    push_byte(8'h00);
    put_point(21'h7FF, 2);
    push_ignored();
    put_point(21'hFFFF, 3);
    put_point(CP_MAX_LEGAL, 4);
    finish_and_send(1'b0);
    // String closed by an item without a byte
    put_point(CP_TWO_MIN, 2);
    finish_and_send(1'b1);
    // Overlong form
    put_point(21'h0, 2);
    finish_and_send(1'b0);
    // Surrogate
    put_point(CP_SURR_LO, 3);
    finish_and_send(1'b0);
    // Beyond the last legal code point
    put_point(CP_LIMIT, 4);
    finish_and_send(1'b0);
    // Bad lead byte, then a byte that must be ignored
    push_byte(8'hFF);
    push_byte(8'h41);
    finish_and_send(1'b0);
    // Bad continuation byte
    push_byte(8'hC2);
    push_byte(8'h41);
    finish_and_send(1'b0);
    // Sequence cut short by the end of the string
    push_byte(8'hE2);
    push_byte(8'h82);
    finish_and_send(1'b0);

    // Random strings under a sequence of bound settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lo = '0;           hi = CP_MAX_LEGAL; end
        1: begin lo = CP_TWO_MIN;   hi = CP_MAX_LEGAL; end
        2: begin lo = '0;           hi = 21'h7F;       end
        3: begin lo = CP_MAX_LEGAL; hi = CP_MAX_LEGAL; end
        4: begin lo = '0;           hi = '0;           end
        5: begin lo = CP_THREE_MIN; hi = 21'hFFFF;     end
        6: begin lo = CP_FOUR_MIN;  hi = 21'h7F;       end
        default: begin
          lo = 21'($urandom_range(0, 21'h7FF));
          hi = 21'($urandom_range(21'h7F, CP_MAX_LEGAL));
        end
      endcase
      set_bounds(lo, hi);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        quiet = ($urandom_range(0, 9) == 0);
        random_string();
      end
      quiet = 1'b0;
    end

    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
